// ----- src/stq_pkg.sv -----
// Shared types, constants and helpers for the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

   // Sizing
   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 32;
   localparam int ID_BITS    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PTR_BITS   = $clog2(NUM_TIMERS + 1);

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;
   typedef logic [TIME_BITS-1:0] time_type;

   // End-of-list marker
   localparam ptr_type NIL = PTR_BITS'(NUM_TIMERS);

   // Request action codes
   typedef enum logic [1:0] {
      ACT_ARM    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_TICK   = 2'd2
   } action_type;

   // Result kinds
   localparam logic KIND_FIRE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNL_START,
      ST_UNL_WALK,
      ST_INS_START,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_ARM_CHECK,
      ST_FIRE,
      ST_ALARM,
      ST_DELTA,
      ST_FINAL
   } state_type;

   // Slot store write request (one address per cycle)
   typedef struct packed {
      logic     data_we;
      logic     link_we;
      logic     mark_we;
      logic     mark_val;
      id_type   addr;
      time_type deadline;
      logic [15:0] ref_val;
      logic [3:0]  hnd;
      ptr_type  link;
   } stq_wr_type;

   // Slot store read data
   typedef struct packed {
      time_type    deadline;
      logic [15:0] ref_val;
      logic [3:0]  hnd;
      ptr_type     link;
      logic        mark;
   } stq_rd_type;

   // Shared subtractor result
   typedef struct packed {
      logic     lt;
      logic     eq;
      time_type diff;
   } alu_res_type;

   // A pointer names a slot when it is below the end marker
   function automatic logic ptr_valid(input ptr_type p);
      return p < NIL;
   endfunction

endpackage

// ----- src/stq_alu.sv -----
// Shared subtract/compare unit used by the insert, head-check, fire, alarm and delta steps of the sequencer.
`timescale 1ns / 1ps

module stq_alu (
   input  stq_pkg::time_type    op_a,
   input  stq_pkg::time_type    op_b,
   output stq_pkg::alu_res_type res
);
   import stq_pkg::*;

   logic [TIME_BITS:0] wide_diff;

   // One subtractor; borrow gives a < b, zero difference gives a == b
   always_comb begin
      wide_diff = {1'b0, op_a} - {1'b0, op_b};
      res.diff  = wide_diff[TIME_BITS-1:0];
      res.lt    = wide_diff[TIME_BITS];
      res.eq    = (wide_diff[TIME_BITS-1:0] == '0);
   end

endmodule

// ----- src/stq_store.sv -----
// Per-slot storage: deadline, reference, handler, link and queued bit.
`timescale 1ns / 1ps

module stq_store (
   input  logic               clock,
   input  logic               reset,
   input  stq_pkg::id_type     rd_addr,
   output stq_pkg::stq_rd_type rd,
   input  stq_pkg::stq_wr_type wr
);
   import stq_pkg::*;

   time_type    deadline_ff [NUM_TIMERS];
   logic [15:0] ref_ff      [NUM_TIMERS];
   logic [3:0]  hnd_ff      [NUM_TIMERS];
   ptr_type     link_ff     [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] mark_ff;

   // Slot payload and links, no reset
   always_ff @(posedge clock) begin
      if (wr.data_we) begin
         deadline_ff[wr.addr] <= wr.deadline;
         ref_ff[wr.addr]      <= wr.ref_val;
         hnd_ff[wr.addr]      <= wr.hnd;
      end
      if (wr.link_we) begin
         link_ff[wr.addr] <= wr.link;
      end
   end

   // Queued bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else if (wr.mark_we) begin
         mark_ff[wr.addr] <= wr.mark_val;
      end
   end

   // Single read address
   always_comb begin
      rd.deadline = deadline_ff[rd_addr];
      rd.ref_val  = ref_ff[rd_addr];
      rd.hnd      = hnd_ff[rd_addr];
      rd.link     = link_ff[rd_addr];
      rd.mark     = mark_ff[rd_addr];
   end

endmodule

// ----- src/sorted_timer_queue_unit.sv -----
// Top level: sequencer walking the deadline-ordered slot list.
//
//   channel | direction | handshake          | item
//   req_*   | in        | req_valid/req_stall | action, slot, deadline, ref, handler, now
//   rsp_*   | out       | rsp_valid/rsp_stall | fired slot or final alarm report
//
// Steps per item after acceptance: decode, an unlink walk when the slot is
// queued, an insert walk when arming, a head check, a fire step per fired slot
// and a final fire check, then the alarm compare and the report. Each insert
// step is one read of the slot store and one pass through the shared
// subtractor; each unlink step is one read of the slot store.
// Reset empties the list and clears the alarm.
// rsp_stall holds the sequencer in its fire and report steps; req_stall is
// high from acceptance until the final report has been loaded.
`timescale 1ns / 1ps

module sorted_timer_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_deadline,
   input  logic [15:0] req_ref_value,
   input  logic [3:0]  req_handler,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_ref_out,
   output logic [3:0]  rsp_handler_out,
   output logic        rsp_alarm_changed,
   output logic [31:0] rsp_alarm_delta,
   output logic        rsp_end_of_run
);
   import stq_pkg::*;

   state_type   state_ff, state_in;
   ptr_type     head_ff, head_in;
   time_type    alarm_ff, alarm_in;
   ptr_type     cur_ff, cur_in;
   ptr_type     prev_ff, prev_in;
   ptr_type     succ_ff, succ_in;

   // Captured request
   action_type  act_ff;
   id_type      id_ff;
   logic        ok_ff;
   time_type    dl_ff;
   logic [15:0] ref_ff;
   logic [3:0]  hnd_ff;
   time_type    now_ff;

   // Result register
   logic        rsp_valid_ff;
   logic        kind_ff, chg_ff;
   logic [3:0]  slot_ff, hout_ff;
   logic [15:0] rout_ff;
   logic [31:0] delta_ff;

   logic        load;
   logic        load_kind, load_chg;
   logic [3:0]  load_slot, load_hnd;
   logic [15:0] load_ref;
   logic [31:0] load_delta;

   id_type      rd_addr;
   stq_rd_type  rd;
   stq_wr_type  wr;
   time_type    alu_a, alu_b;
   alu_res_type alu;

   logic        head_ok, cur_ok, load_ok, req_take;
   ptr_type     id_ptr;
   state_type   unl_ret;

   stq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd      (rd),
      .wr      (wr)
   );

   stq_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu)
   );

   // Common conditions
   always_comb begin
      head_ok  = ptr_valid(head_ff);
      cur_ok   = ptr_valid(cur_ff);
      load_ok  = !rsp_valid_ff || !rsp_stall;
      id_ptr   = PTR_BITS'(id_ff);
      unl_ret  = (act_ff == ACT_ARM) ? ST_INS_START : ST_FIRE;
      req_take = req_valid && !req_stall;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (act_ff)
               ACT_ARM: begin
                  if (!ok_ff)       state_in = ST_ARM_CHECK;
                  else if (rd.mark) state_in = ST_UNL_START;
                  else              state_in = ST_INS_START;
               end
               ACT_CANCEL: state_in = (ok_ff && rd.mark) ? ST_UNL_START : ST_FIRE;
               ACT_TICK:   state_in = ST_FIRE;
               default:    state_in = ST_FINAL;
            endcase
         end
         ST_UNL_START: begin
            state_in = (head_ff == id_ptr) ? unl_ret : ST_UNL_WALK;
         end
         ST_UNL_WALK: begin
            if (!cur_ok || rd.link == id_ptr) state_in = unl_ret;
         end
         ST_INS_START: begin
            if (!head_ok || alu.lt) state_in = ST_ARM_CHECK;
            else                    state_in = ST_INS_WALK;
         end
         ST_INS_WALK: begin
            if (!cur_ok || alu.lt || alu.eq) state_in = ST_INS_LINK;
         end
         ST_INS_LINK: state_in = ST_ARM_CHECK;
         ST_ARM_CHECK: begin
            state_in = (head_ok && !alu.eq) ? ST_FIRE : ST_FINAL;
         end
         ST_FIRE: begin
            if (!(head_ok && !alu.lt)) state_in = ST_ALARM;
         end
         ST_ALARM: state_in = alu.eq ? ST_FINAL : ST_DELTA;
         ST_DELTA: begin
            if (load_ok) state_in = ST_IDLE;
         end
         ST_FINAL: begin
            if (load_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      rd_addr    = cur_ff[ID_BITS-1:0];
      wr         = '0;
      wr.addr    = id_ff;
      alu_a      = dl_ff;
      alu_b      = rd.deadline;
      head_in    = head_ff;
      alarm_in   = alarm_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      succ_in    = succ_ff;
      load       = 1'b0;
      load_kind  = KIND_REPORT;
      load_slot  = '0;
      load_ref   = '0;
      load_hnd   = '0;
      load_chg   = 1'b0;
      load_delta = '0;
      case (state_ff)
         ST_DECODE: begin
            rd_addr = id_ff;
            if (act_ff == ACT_TICK) alarm_in = '0;
         end
         // Unlink: clear queued bit, keep successor
         ST_UNL_START: begin
            rd_addr     = id_ff;
            wr.mark_we  = 1'b1;
            wr.mark_val = 1'b0;
            succ_in     = rd.link;
            if (head_ff == id_ptr) head_in = rd.link;
            else                   cur_in  = head_ff;
         end
         // Find the predecessor and splice around the slot
         ST_UNL_WALK: begin
            if (cur_ok && rd.link == id_ptr) begin
               wr.link_we = 1'b1;
               wr.addr    = cur_ff[ID_BITS-1:0];
               wr.link    = succ_ff;
            end else begin
               cur_in = rd.link;
            end
         end
         // Write slot data; place at head when it goes first
         ST_INS_START: begin
            rd_addr     = head_ff[ID_BITS-1:0];
            wr.data_we  = 1'b1;
            wr.link_we  = 1'b1;
            wr.mark_we  = 1'b1;
            wr.mark_val = 1'b1;
            wr.deadline = dl_ff;
            wr.ref_val  = ref_ff;
            wr.hnd      = hnd_ff;
            wr.link     = NIL;
            if (!head_ok) begin
               head_in = id_ptr;
            end else if (alu.lt) begin
               wr.link = head_ff;
               head_in = id_ptr;
            end else begin
               prev_in = head_ff;
               cur_in  = rd.link;
            end
         end
         // Stop before the first entry whose deadline is not below the new one
         ST_INS_WALK: begin
            if (!cur_ok || alu.lt || alu.eq) begin
               wr.link_we = 1'b1;
               wr.link    = cur_ff;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd.link;
            end
         end
         ST_INS_LINK: begin
            wr.link_we = 1'b1;
            wr.addr    = prev_ff[ID_BITS-1:0];
            wr.link    = id_ptr;
         end
         ST_ARM_CHECK: begin
            rd_addr = head_ff[ID_BITS-1:0];
            alu_a   = rd.deadline;
            alu_b   = alarm_ff;
         end
         // Pop expired head entries, one per cycle while the result register can be loaded
         ST_FIRE: begin
            rd_addr = head_ff[ID_BITS-1:0];
            alu_a   = now_ff;
            alu_b   = rd.deadline;
            if (head_ok && !alu.lt && load_ok) begin
               head_in     = rd.link;
               wr.mark_we  = 1'b1;
               wr.mark_val = 1'b0;
               wr.addr     = head_ff[ID_BITS-1:0];
               load        = 1'b1;
               load_kind   = KIND_FIRE;
               load_slot   = 4'(head_ff[ID_BITS-1:0]);
               load_ref    = rd.ref_val;
               load_hnd    = rd.hnd;
            end
         end
         // Compare new head deadline with the programmed alarm
         ST_ALARM: begin
            rd_addr = head_ff[ID_BITS-1:0];
            alu_a   = head_ok ? rd.deadline : '0;
            alu_b   = alarm_ff;
            if (!alu.eq) alarm_in = alu_a;
         end
         ST_DELTA: begin
            alu_a = alarm_ff;
            alu_b = now_ff;
            if (load_ok) begin
               load       = 1'b1;
               load_chg   = 1'b1;
               load_delta = (alarm_ff != '0) ? 32'(alu.diff) : '0;
            end
         end
         ST_FINAL: begin
            load = load_ok;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         alarm_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         alarm_ff <= alarm_in;
         if (load)            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Working pointers, captured request and result payload
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      succ_ff <= succ_in;
      if (req_take) begin
         act_ff <= action_type'(req_action);
         id_ff  <= ID_BITS'(req_timer_id);
         ok_ff  <= (32'(req_timer_id) < 32'(NUM_TIMERS));
         dl_ff  <= TIME_BITS'(req_deadline);
         ref_ff <= req_ref_value;
         hnd_ff <= req_handler;
         now_ff <= TIME_BITS'(req_now);
      end
      if (load) begin
         kind_ff  <= load_kind;
         slot_ff  <= load_slot;
         rout_ff  <= load_ref;
         hout_ff  <= load_hnd;
         chg_ff   <= load_chg;
         delta_ff <= load_delta;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_ref_out       = rout_ff;
   assign rsp_handler_out   = hout_ff;
   assign rsp_alarm_changed = chg_ff;
   assign rsp_alarm_delta   = delta_ff;
   assign rsp_end_of_run    = kind_ff;

endmodule

// ----- src/stq_checker.sv -----
// Port-level checks for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps

module stq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic        rsp_alarm_changed,
   input logic [31:0] rsp_alarm_delta,
   input logic        rsp_end_of_run
);
   import stq_pkg::*;

   logic [1:0] open_cnt_ff;
   logic       req_take;
   logic       run_done;

   always_comb begin
      req_take = req_valid && !req_stall;
      run_done = rsp_valid && !rsp_stall && rsp_end_of_run;
   end

   // Open items: accepted and final report not yet taken
   always_ff @(posedge clock) begin
      if (reset) begin
         open_cnt_ff <= '0;
      end else if (req_take && !run_done) begin
         open_cnt_ff <= open_cnt_ff + 2'd1;
      end else if (!req_take && run_done) begin
         open_cnt_ff <= open_cnt_ff - 2'd1;
      end
   end

   // A new item may start only behind a waiting final report, never deeper
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (open_cnt_ff == 2'd2) |-> req_stall)
      else $error("item taken while two runs open");

   // Results only belong to an open item
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_cnt_ff != 2'd0))
      else $error("result without open item");

   // Run ends exactly on the report item
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_run == (rsp_kind == KIND_REPORT)))
      else $error("end_of_run and kind disagree");

   // Fire items carry no alarm information
   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FIRE) |-> (!rsp_alarm_changed && rsp_alarm_delta == '0))
      else $error("fire item carries alarm fields");

   // Unchanged alarm reports zero delta
   a_delta_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_alarm_changed) |-> (rsp_alarm_delta == '0))
      else $error("delta without alarm change");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

// ----- tb/sv/sorted_timer_queue_unit_test.sv -----
// Self-checking testbench for the sorted timer queue: directed and random traffic.
`timescale 1ns / 1ps

module sorted_timer_queue_unit_test;
   import stq_pkg::*;

   // Action code the block must treat as a no-op
   localparam logic [1:0] ACT_UNDEFINED = 2'd3;
   localparam int SETTLE_CYCLES = 80;
   localparam int PRINT_CAP     = 50;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  timer_id;
      logic [31:0] deadline;
      logic [15:0] ref_value;
      logic [3:0]  handler;
      logic [31:0] now;
   } timer_req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [15:0] ref_out;
      logic [3:0]  hnd;
      logic        chg;
      logic [31:0] delta;
      logic        eor;
   } fire_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [3:0]  req_timer_id = '0;
   logic [31:0] req_deadline = '0;
   logic [15:0] req_ref_value = '0;
   logic [3:0]  req_handler = '0;
   logic [31:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_ref_out;
   logic [3:0]  rsp_handler_out;
   logic        rsp_alarm_changed;
   logic [31:0] rsp_alarm_delta;
   logic        rsp_end_of_run;

   // Expected fire and report items, oldest first
   fire_report_type due_results[$];
   int fail_count = 0;
   int results_seen = 0;
   int burst_left = 0;
   int hold_request = 0;

   // Shadow copy of the timer list
   time_type    q_deadline [NUM_TIMERS];
   logic [15:0] q_ref      [NUM_TIMERS];
   logic [3:0]  q_hnd      [NUM_TIMERS];
   ptr_type     q_link     [NUM_TIMERS];
   logic        q_linked   [NUM_TIMERS];
   ptr_type     q_head;
   time_type    q_alarm;

   sorted_timer_queue_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_timer_id      (req_timer_id),
      .req_deadline      (req_deadline),
      .req_ref_value     (req_ref_value),
      .req_handler       (req_handler),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_slot          (rsp_slot),
      .rsp_ref_out       (rsp_ref_out),
      .rsp_handler_out   (rsp_handler_out),
      .rsp_alarm_changed (rsp_alarm_changed),
      .rsp_alarm_delta   (rsp_alarm_delta),
      .rsp_end_of_run    (rsp_end_of_run)
   );

   always #5 clock = ~clock;

   // Run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic log_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         log_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                                want));
   endtask

   // ---------------- list model ----------------

   function automatic void list_unlink(input int id);
      ptr_type p;
      if (!q_linked[id]) return;
      q_linked[id] = 1'b0;
      if (q_head == id) begin
         q_head = q_link[id];
         return;
      end
      p = q_head;
      for (int n = 0; n < NUM_TIMERS && p < NIL; n++) begin
         if (q_link[p] == id) begin
            q_link[p] = q_link[id];
            return;
         end
         p = q_link[p];
      end
   endfunction

   // Ordered insert; equal deadlines go after the head, ahead of other equals
   function automatic void list_insert(input int id, input time_type d);
      ptr_type p;
      ptr_type q;
      q_linked[id] = 1'b1;
      q_link[id] = NIL;
      if (q_head >= NIL) begin
         q_head = ptr_type'(id);
         return;
      end
      if (d < q_deadline[q_head]) begin
         q_link[id] = q_head;
         q_head = ptr_type'(id);
         return;
      end
      p = q_head;
      for (int n = 0; n < NUM_TIMERS; n++) begin
         q = q_link[p];
         if (q >= NIL || !(q_deadline[q] < d)) break;
         p = q;
      end
      q_link[id] = q_link[p];
      q_link[p] = ptr_type'(id);
   endfunction

   function automatic void push_report(input logic chg, input time_type delta);
      fire_report_type r;
      r = '0;
      r.kind  = KIND_REPORT;
      r.chg   = chg;
      r.delta = delta;
      r.eor   = 1'b1;
      due_results.push_back(r);
   endfunction

   // Pop every due entry, then reprogram the alarm to the new head
   function automatic void expire_and_rearm(input time_type now);
      int k;
      ptr_type h;
      time_type nt;
      fire_report_type r;
      k = 0;
      while (q_head < NIL && k < NUM_TIMERS && q_deadline[q_head] <= now) begin
         h = q_head;
         q_head = q_link[h];
         q_linked[h] = 1'b0;
         r = '0;
         r.kind    = KIND_FIRE;
         r.slot    = h[3:0];
         r.ref_out = q_ref[h];
         r.hnd     = q_hnd[h];
         due_results.push_back(r);
         k++;
      end
      nt = (q_head < NIL) ? q_deadline[q_head] : '0;
      if (nt != q_alarm) begin
         q_alarm = nt;
         push_report(1'b1, (nt != 0) ? nt - now : '0);
      end else begin
         push_report(1'b0, '0);
      end
   endfunction

   function automatic void predict_timer_results(input timer_req_type r);
      int id;
      id = r.timer_id;
      case (r.action)
         ACT_ARM: begin
            list_unlink(id);
            q_deadline[id] = r.deadline;
            q_ref[id] = r.ref_value;
            q_hnd[id] = r.handler;
            list_insert(id, r.deadline);
            if (q_head < NIL && q_deadline[q_head] != q_alarm) expire_and_rearm(r.now);
            else push_report(1'b0, '0);
         end
         ACT_CANCEL: begin
            list_unlink(id);
            expire_and_rearm(r.now);
         end
         ACT_TICK: begin
            q_alarm = '0;
            expire_and_rearm(r.now);
         end
         default: push_report(1'b0, '0);
      endcase
   endfunction

   // ---------------- drivers ----------------

   // Offer one item; bursts of random length with random gaps in between
   task automatic send_req(input timer_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(8, 1);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= r.action;
      req_timer_id  <= r.timer_id;
      req_deadline  <= r.deadline;
      req_ref_value <= r.ref_value;
      req_handler   <= r.handler;
      req_now       <= r.now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_timer_results(r);
   endtask

   function automatic timer_req_type make_req(input logic [1:0] action, input int id,
                                              input logic [31:0] deadline,
                                              input logic [15:0] ref_value,
                                              input logic [3:0] handler,
                                              input logic [31:0] now);
      timer_req_type r;
      r.action    = action;
      r.timer_id  = id[3:0];
      r.deadline  = deadline;
      r.ref_value = ref_value;
      r.handler   = handler;
      r.now       = now;
      return r;
   endfunction

   // Receiver stall: random-density stretches, plus long hold-offs on request
   always @(negedge clock) begin : stall_gen
      static int mode_left = 0;
      static int stall_pct = 0;
      static int hold_left = 0;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         mode_left = $urandom_range(60, 5);
         case ($urandom_range(2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 75;
         endcase
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin : result_check
      fire_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result kind %0d slot %0d", rsp_kind,
                                   rsp_slot));
         end else begin
            want = due_results.pop_front();
            check_field("kind", rsp_kind, want.kind);
            check_field("slot", rsp_slot, want.slot);
            check_field("ref_out", rsp_ref_out, want.ref_out);
            check_field("handler_out", rsp_handler_out, want.hnd);
            check_field("alarm_changed", rsp_alarm_changed, want.chg);
            check_field("alarm_delta", rsp_alarm_delta, want.delta);
            check_field("end_of_run", rsp_end_of_run, want.eor);
         end
         results_seen++;
      end
   end

   // ---------------- tests ----------------

   // Empty list, unknown action, extremes, equal deadlines, re-arm of the head
   task automatic test_directed_basics();
      send_req(make_req(ACT_TICK, 0, '0, '0, '0, '0));
      send_req(make_req(ACT_CANCEL, 5, '0, '0, '0, '0));
      send_req(make_req(ACT_UNDEFINED, 15, '1, '1, '1, '1));
      send_req(make_req(ACT_ARM, 0, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 0));
      send_req(make_req(ACT_ARM, 1, 100, 16'h0000, 4'h0, 0));
      // equal to the head: no re-check, lands after the head
      send_req(make_req(ACT_ARM, 2, 100, 16'h1234, 4'h3, 0));
      send_req(make_req(ACT_ARM, 3, 100, 16'hA5A5, 4'h5, 0));
      // already due on arm: fires at once
      send_req(make_req(ACT_ARM, 4, 0, 16'h5A5A, 4'hA, 0));
      send_req(make_req(ACT_ARM, 1, 200, 16'h0F0F, 4'h7, 10));
      send_req(make_req(ACT_TICK, 9, '0, '0, '0, 100));
      send_req(make_req(ACT_CANCEL, 1, '0, '0, '0, 150));
      send_req(make_req(ACT_CANCEL, 0, '0, '0, '0, 32'hFFFF_FFFF));
   endtask

   // Fill every slot, then one tick fires the whole list
   task automatic test_fire_all();
      for (int i = 0; i < NUM_TIMERS; i++)
         send_req(make_req(ACT_ARM, NUM_TIMERS - 1 - i, 1000 + $urandom_range(8),
                           16'($urandom), 4'($urandom), 500));
      send_req(make_req(ACT_TICK, 0, '0, '0, '0, 2000));
   endtask

   // Long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      time_type base;
      base = 32'h4000_0000;
      hold_request = 400;
      for (int i = 0; i < 10; i++)
         send_req(make_req(ACT_ARM, $urandom_range(15), base + $urandom_range(50),
                           16'($urandom), 4'($urandom), base));
      send_req(make_req(ACT_TICK, 0, '0, '0, '0, base + 25));
      send_req(make_req(ACT_TICK, 0, '0, '0, '0, base + 60));
   endtask

   // Mostly coherent time flow with small lookahead, plus full-range noise
   task automatic test_random_traffic(input int count);
      timer_req_type r;
      time_type tnow;
      int pick;
      tnow = $urandom_range(32'h7FFF_FFFF);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         tnow += $urandom_range(40);
         r.timer_id  = 4'($urandom_range(15));
         r.ref_value = 16'($urandom);
         r.handler   = 4'($urandom_range(15));
         r.now       = tnow;
         r.deadline  = tnow + $urandom_range(120);
         if (pick < 50) r.action = ACT_ARM;
         else if (pick < 68) r.action = ACT_CANCEL;
         else if (pick < 86) r.action = ACT_TICK;
         else if (pick < 91) r.action = ACT_UNDEFINED;
         else begin
            r.action   = 2'($urandom_range(3));
            r.deadline = $urandom;
            r.now      = $urandom;
         end
         send_req(r);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         q_deadline[i] = '0;
         q_ref[i] = '0;
         q_hnd[i] = '0;
         q_link[i] = NIL;
         q_linked[i] = 1'b0;
      end
      q_head = NIL;
      q_alarm = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_fire_all();
      test_backpressure();
      test_random_traffic(410);

      // Stop offering, drain, then let the block settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", due_results.size()));

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/stq_pkg.sv
src/stq_alu.sv
src/stq_store.sv
src/sorted_timer_queue_unit.sv
src/stq_checker.sv
tb/sv/sorted_timer_queue_unit_test.sv
